@@ hdl/e2r_pkg.sv @@
// Shared constants, tables, types and helper functions for the Euler angle rotation block.
package e2r_pkg;

   // Default configuration of the block.
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_BITS_DEF   = 16;

   // Fixed datapath widths: CORDIC x/y are Q30 in 32 bits, products are Q60 in 64 bits.
   localparam int XW = 32;
   localparam int PW = 2 * XW;
   // Extra integer bits of the angle accumulator above its fractional bits.
   localparam int Z_GUARD = 5;
   localparam int IN_W = 16;
   localparam int OUT_W = 16;

   localparam int NUM_ANGLES = 3;
   localparam int HEADING = 0;
   localparam int PITCH   = 1;
   localparam int BANK    = 2;

   localparam int NUM_ENTRIES = 9;
   localparam int I_X = 0;
   localparam int I_Y = 1;
   localparam int I_Z = 2;
   localparam int J_X = 3;
   localparam int J_Y = 4;
   localparam int J_Z = 5;
   localparam int K_X = 6;
   localparam int K_Y = 7;
   localparam int K_Z = 8;

   localparam int TAB_LEN = 24;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint GAIN_INF    = 64'sd652032874;
   localparam longint GAIN_TAIL   = 64'sd434688583;

   localparam longint ATAN_Q30 [TAB_LEN] = '{
      64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
      64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
      64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
      64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767,
      64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047,
      64'sd1023,      64'sd511,       64'sd255,       64'sd127
   };

   // One angle's rotating vector plus the flag that says it must be negated at the end.
   typedef struct packed {
      logic                 flip;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
   } vec_type;

   // Rounds a Q30 table constant half up to ab fractional bits.
   function automatic longint tab_conv(input longint t, input int ab);
      longint half;
      if (ab <= 30) begin
         half = (64'sd1 <<< (30 - ab)) >>> 1;
         return (t + half) >>> (30 - ab);
      end
      return t <<< (ab - 30);
   endfunction

   function automatic longint atan_conv(input int step, input int ab);
      return tab_conv(ATAN_Q30[step], ab);
   endfunction

   // Start value of x, pre-scaled by the inverse CORDIC gain for n steps.
   function automatic longint gain_q30(input int n);
      longint tail;
      tail = (GAIN_TAIL + (64'sd1 <<< (2 * n - 1))) >>> (2 * n);
      return GAIN_INF + tail;
   endfunction

endpackage

@@ hdl/e2r_reduce.sv @@
// Input cell: angle scaling, quadrant folding into [-pi/2, pi/2] and CORDIC start values.
module e2r_reduce #(
   parameter int CORDIC_STEPS = e2r_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_BITS   = e2r_pkg::ANGLE_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      up_valid,
   output logic                                      up_ready,
   input  logic signed [e2r_pkg::IN_W-1:0]           up_angle [e2r_pkg::NUM_ANGLES],
   output logic                                      dn_valid,
   input  logic                                      dn_ready,
   output e2r_pkg::vec_type                          dn_vec [e2r_pkg::NUM_ANGLES],
   output logic signed [ANGLE_BITS+e2r_pkg::Z_GUARD-1:0] dn_z [e2r_pkg::NUM_ANGLES]
);
   import e2r_pkg::*;

   localparam int ZW = ANGLE_BITS + Z_GUARD;
   localparam int IN_UP = (ANGLE_BITS >= 13) ? ANGLE_BITS - 13 : 0;
   localparam int IN_DN = (ANGLE_BITS < 13) ? 13 - ANGLE_BITS : 0;
   localparam logic signed [ZW-1:0] PI_Z      = ZW'(tab_conv(PI_Q30, ANGLE_BITS));
   localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(tab_conv(HALF_PI_Q30, ANGLE_BITS));
   localparam logic signed [XW-1:0] GAIN      = XW'(gain_q30(CORDIC_STEPS));

   logic                 valid_ff;
   vec_type              vec_ff [NUM_ANGLES];
   vec_type              vec_in [NUM_ANGLES];
   logic signed [ZW-1:0] z_ff   [NUM_ANGLES];
   logic signed [ZW-1:0] z_in   [NUM_ANGLES];

   // No transaction is taken while reset is high.
   assign up_ready = !reset && (!valid_ff || dn_ready);
   assign dn_valid = valid_ff;
   assign dn_vec   = vec_ff;
   assign dn_z     = z_ff;

   always_comb begin
      logic signed [ZW-1:0] ext;
      logic signed [ZW-1:0] z0;
      for (int a = 0; a < NUM_ANGLES; a++) begin
         ext = $signed({{(ZW-IN_W){up_angle[a][IN_W-1]}}, up_angle[a]});
         z0  = (ext <<< IN_UP) >>> IN_DN;
         vec_in[a].x = GAIN;
         vec_in[a].y = '0;
         if (z0 > HALF_PI_Z) begin
            z_in[a]        = z0 - PI_Z;
            vec_in[a].flip = 1'b1;
         end else if (z0 < -HALF_PI_Z) begin
            z_in[a]        = z0 + PI_Z;
            vec_in[a].flip = 1'b1;
         end else begin
            z_in[a]        = z0;
            vec_in[a].flip = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         vec_ff <= vec_in;
         z_ff   <= z_in;
      end
   end

endmodule

@@ hdl/e2r_cordic_cell.sv @@
// One rotation-mode CORDIC iteration for all three angles, with its own stage register.
module e2r_cordic_cell #(
   parameter int ANGLE_BITS = e2r_pkg::ANGLE_BITS_DEF,
   parameter int STEP       = 0
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      up_valid,
   output logic                                      up_ready,
   input  e2r_pkg::vec_type                          up_vec [e2r_pkg::NUM_ANGLES],
   input  logic signed [ANGLE_BITS+e2r_pkg::Z_GUARD-1:0] up_z [e2r_pkg::NUM_ANGLES],
   output logic                                      dn_valid,
   input  logic                                      dn_ready,
   output e2r_pkg::vec_type                          dn_vec [e2r_pkg::NUM_ANGLES],
   output logic signed [ANGLE_BITS+e2r_pkg::Z_GUARD-1:0] dn_z [e2r_pkg::NUM_ANGLES]
);
   import e2r_pkg::*;

   localparam int ZW = ANGLE_BITS + Z_GUARD;
   localparam logic signed [ZW-1:0] ATAN = ZW'(atan_conv(STEP, ANGLE_BITS));

   logic                 valid_ff;
   vec_type              vec_ff [NUM_ANGLES];
   vec_type              vec_in [NUM_ANGLES];
   logic signed [ZW-1:0] z_ff   [NUM_ANGLES];
   logic signed [ZW-1:0] z_in   [NUM_ANGLES];

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_vec   = vec_ff;
   assign dn_z     = z_ff;

   always_comb begin
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      for (int a = 0; a < NUM_ANGLES; a++) begin
         dx = $signed(up_vec[a].y) >>> STEP;
         dy = $signed(up_vec[a].x) >>> STEP;
         vec_in[a].flip = up_vec[a].flip;
         // Rotate toward zero residual angle; the old x and y feed both updates.
         if (!up_z[a][ZW-1]) begin
            vec_in[a].x = $signed(up_vec[a].x) - dx;
            vec_in[a].y = $signed(up_vec[a].y) + dy;
            z_in[a]     = up_z[a] - ATAN;
         end else begin
            vec_in[a].x = $signed(up_vec[a].x) + dx;
            vec_in[a].y = $signed(up_vec[a].y) - dy;
            z_in[a]     = up_z[a] + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         vec_ff <= vec_in;
         z_ff   <= z_in;
      end
   end

endmodule

@@ hdl/e2r_combine.sv @@
// Sine/cosine sign fix, matrix products, rounding to Q1.14 and saturation, over four stages.
module e2r_combine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  e2r_pkg::vec_type                    up_vec [e2r_pkg::NUM_ANGLES],
   output logic                                dn_valid,
   input  logic                                dn_ready,
   output logic signed [e2r_pkg::OUT_W-1:0]    dn_entry [e2r_pkg::NUM_ENTRIES]
);
   import e2r_pkg::*;

   localparam logic signed [PW:0] ROUND_Q60 = 65'sd35184372088832;
   localparam logic signed [PW:0] ONE_Q14   = 65'sd16384;

   function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [PW:0] v);
      logic signed [PW:0] r;
      r = (v + ROUND_Q60) >>> 46;
      if (r > ONE_Q14) begin
         return OUT_W'(ONE_Q14);
      end else if (r < -ONE_Q14) begin
         return OUT_W'(-ONE_Q14);
      end
      return r[OUT_W-1:0];
   endfunction

   function automatic logic signed [PW:0] ext(input logic signed [PW-1:0] p);
      return $signed({p[PW-1], p});
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1, r2, r3, r4;

   assign r4       = !v4_ff || dn_ready;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign up_ready = r1;
   assign dn_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= up_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: undo the half-turn folding by negating sine and cosine.
   logic signed [XW-1:0] s_ff [NUM_ANGLES];
   logic signed [XW-1:0] c_ff [NUM_ANGLES];
   logic signed [XW-1:0] s_in [NUM_ANGLES];
   logic signed [XW-1:0] c_in [NUM_ANGLES];

   always_comb begin
      for (int a = 0; a < NUM_ANGLES; a++) begin
         s_in[a] = up_vec[a].flip ? -$signed(up_vec[a].y) : $signed(up_vec[a].y);
         c_in[a] = up_vec[a].flip ? -$signed(up_vec[a].x) : $signed(up_vec[a].x);
      end
   end

   always_ff @(posedge clock) begin
      if (r1 && up_valid) begin
         s_ff <= s_in;
         c_ff <= c_in;
      end
   end

   // Stage 2: all two-factor products at Q60.
   logic signed [PW-1:0] shsp2_ff, chsp2_ff, chcb2_ff, sbcp2_ff, shcb2_ff;
   logic signed [PW-1:0] chsb2_ff, cbcp2_ff, sbsh2_ff, shcp2_ff, chcp2_ff;
   logic signed [XW-1:0] sp2_ff, sb2_ff, cb2_ff;

   always_ff @(posedge clock) begin
      if (r2 && v1_ff) begin
         shsp2_ff <= s_ff[HEADING] * s_ff[PITCH];
         chsp2_ff <= c_ff[HEADING] * s_ff[PITCH];
         chcb2_ff <= c_ff[HEADING] * c_ff[BANK];
         sbcp2_ff <= s_ff[BANK] * c_ff[PITCH];
         shcb2_ff <= s_ff[HEADING] * c_ff[BANK];
         chsb2_ff <= c_ff[HEADING] * s_ff[BANK];
         cbcp2_ff <= c_ff[BANK] * c_ff[PITCH];
         sbsh2_ff <= s_ff[BANK] * s_ff[HEADING];
         shcp2_ff <= s_ff[HEADING] * c_ff[PITCH];
         chcp2_ff <= c_ff[HEADING] * c_ff[PITCH];
         sp2_ff   <= s_ff[PITCH];
         sb2_ff   <= s_ff[BANK];
         cb2_ff   <= c_ff[BANK];
      end
   end

   // Stage 3: triple products, with sh*sp and ch*sp floored back to Q30 first.
   logic signed [XW-1:0] shsp_q30, chsp_q30;
   logic signed [PW-1:0] shspsb3_ff, chspsb3_ff, shspcb3_ff, chspcb3_ff;
   logic signed [PW-1:0] chcb3_ff, sbcp3_ff, shcb3_ff, chsb3_ff;
   logic signed [PW-1:0] cbcp3_ff, sbsh3_ff, shcp3_ff, chcp3_ff;
   logic signed [XW-1:0] sp3_ff;

   assign shsp_q30 = $signed(shsp2_ff[XW+29:30]);
   assign chsp_q30 = $signed(chsp2_ff[XW+29:30]);

   always_ff @(posedge clock) begin
      if (r3 && v2_ff) begin
         shspsb3_ff <= shsp_q30 * sb2_ff;
         chspsb3_ff <= chsp_q30 * sb2_ff;
         shspcb3_ff <= shsp_q30 * cb2_ff;
         chspcb3_ff <= chsp_q30 * cb2_ff;
         chcb3_ff   <= chcb2_ff;
         sbcp3_ff   <= sbcp2_ff;
         shcb3_ff   <= shcb2_ff;
         chsb3_ff   <= chsb2_ff;
         cbcp3_ff   <= cbcp2_ff;
         sbsh3_ff   <= sbsh2_ff;
         shcp3_ff   <= shcp2_ff;
         chcp3_ff   <= chcp2_ff;
         sp3_ff     <= sp2_ff;
      end
   end

   // Stage 4: sums, rounding and saturation into the output register.
   logic signed [OUT_W-1:0] entry_ff [NUM_ENTRIES];
   logic signed [OUT_W-1:0] entry_in [NUM_ENTRIES];
   logic signed [PW:0]      neg_sp_q60;

   assign neg_sp_q60 = -($signed({{(PW-XW+1){sp3_ff[XW-1]}}, sp3_ff}) <<< 30);

   always_comb begin
      entry_in[I_X] = to_q14(ext(chcb3_ff) + ext(shspsb3_ff));
      entry_in[I_Y] = to_q14(ext(sbcp3_ff));
      entry_in[I_Z] = to_q14(ext(chspsb3_ff) - ext(shcb3_ff));
      entry_in[J_X] = to_q14(ext(shspcb3_ff) - ext(chsb3_ff));
      entry_in[J_Y] = to_q14(ext(cbcp3_ff));
      entry_in[J_Z] = to_q14(ext(sbsh3_ff) + ext(chspcb3_ff));
      entry_in[K_X] = to_q14(ext(shcp3_ff));
      entry_in[K_Y] = to_q14(neg_sp_q60);
      entry_in[K_Z] = to_q14(ext(chcp3_ff));
   end

   always_ff @(posedge clock) begin
      if (r4 && v3_ff) begin
         entry_ff <= entry_in;
      end
   end

   assign dn_entry = entry_ff;

endmodule

@@ hdl/euler_to_rotation_matrix.sv @@
// Top level: heading/pitch/bank angles in, 3x3 rotation matrix out.
//
// Request channel (req_*): one transaction carries heading, pitch and bank as
// signed Q3.13 radians; every bit pattern is a legal angle.
// Response channel (rsp_*): one transaction per request, in order, carrying the
// nine matrix entries as signed Q1.14, saturated to +-1.0.
// Pipeline: an accepted request passes through one folding cell, one cell per
// CORDIC iteration, and four product/rounding stages before rsp_valid rises.
// Throughput is one transaction per cycle while rsp_ready is high. Every
// stage holds one transaction and loads whenever it is empty or its
// successor moves, so a stalled response only backs the pipeline up once
// all stages are full; until then new requests keep being accepted.
// Synchronous reset clears all stage valid flags and holds req_ready low; no
// results are pending afterwards and req_ready is high in the first cycle after
// reset is released.
module euler_to_rotation_matrix #(
   parameter int CORDIC_STEPS = e2r_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_BITS   = e2r_pkg::ANGLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_heading,
   input  logic signed [15:0] req_pitch,
   input  logic signed [15:0] req_bank,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_basis_i_x,
   output logic signed [15:0] rsp_basis_i_y,
   output logic signed [15:0] rsp_basis_i_z,
   output logic signed [15:0] rsp_basis_j_x,
   output logic signed [15:0] rsp_basis_j_y,
   output logic signed [15:0] rsp_basis_j_z,
   output logic signed [15:0] rsp_basis_k_x,
   output logic signed [15:0] rsp_basis_k_y,
   output logic signed [15:0] rsp_basis_k_z
);
   import e2r_pkg::*;

   localparam int ZW = ANGLE_BITS + Z_GUARD;

   logic signed [IN_W-1:0]  angle_s [NUM_ANGLES];
   logic                    valid_s [CORDIC_STEPS+1];
   logic                    ready_s [CORDIC_STEPS+1];
   vec_type                 vec_s   [CORDIC_STEPS+1][NUM_ANGLES];
   logic signed [ZW-1:0]    z_s     [CORDIC_STEPS+1][NUM_ANGLES];
   logic signed [OUT_W-1:0] entry_s [NUM_ENTRIES];

   assign angle_s[HEADING] = req_heading;
   assign angle_s[PITCH]   = req_pitch;
   assign angle_s[BANK]    = req_bank;

   e2r_reduce #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .ANGLE_BITS   (ANGLE_BITS)
   ) u_reduce (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_angle (angle_s),
      .dn_valid (valid_s[0]),
      .dn_ready (ready_s[0]),
      .dn_vec   (vec_s[0]),
      .dn_z     (z_s[0])
   );

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      e2r_cordic_cell #(
         .ANGLE_BITS (ANGLE_BITS),
         .STEP       (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_s[k]),
         .up_ready (ready_s[k]),
         .up_vec   (vec_s[k]),
         .up_z     (z_s[k]),
         .dn_valid (valid_s[k+1]),
         .dn_ready (ready_s[k+1]),
         .dn_vec   (vec_s[k+1]),
         .dn_z     (z_s[k+1])
      );
   end

   // The residual angle of the last cell is not needed further.
   e2r_combine u_combine (
      .clock    (clock),
      .reset    (reset),
      .up_valid (valid_s[CORDIC_STEPS]),
      .up_ready (ready_s[CORDIC_STEPS]),
      .up_vec   (vec_s[CORDIC_STEPS]),
      .dn_valid (rsp_valid),
      .dn_ready (rsp_ready),
      .dn_entry (entry_s)
   );

   assign rsp_basis_i_x = entry_s[I_X];
   assign rsp_basis_i_y = entry_s[I_Y];
   assign rsp_basis_i_z = entry_s[I_Z];
   assign rsp_basis_j_x = entry_s[J_X];
   assign rsp_basis_j_y = entry_s[J_Y];
   assign rsp_basis_j_z = entry_s[J_Z];
   assign rsp_basis_k_x = entry_s[K_X];
   assign rsp_basis_k_y = entry_s[K_Y];
   assign rsp_basis_k_z = entry_s[K_Z];

endmodule

@@ test/tb_euler_to_rotation_matrix.sv @@
// Self-checking testbench for the heading-pitch-bank to rotation matrix block.
`timescale 1ns / 1ps

module tb_euler_to_rotation_matrix;
   import e2r_pkg::*;

   localparam int STEP_COUNT = 16;
   localparam int Z_FRAC = 16;
   localparam int TAB_SHIFT = 30 - Z_FRAC;
   localparam longint TAB_HALF = 64'sd1 <<< (TAB_SHIFT - 1);
   localparam longint PI_Z = (64'sd3373259426 + TAB_HALF) >>> TAB_SHIFT;
   localparam longint HALF_PI_Z = (64'sd1686629713 + TAB_HALF) >>> TAB_SHIFT;
   localparam longint CORDIC_X0 = 64'sd652032874
      + ((64'sd434688583 + (64'sd1 <<< (2 * STEP_COUNT - 1))) >>> (2 * STEP_COUNT));
   localparam longint ARCTAN_Q30 [STEP_COUNT] = '{
      64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
      64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
      64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
      64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767
   };
   localparam logic [15:0] ONE_Q14 = 16'd16384;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   // Angles at the range-reduction thresholds (+-pi/2), at +-pi, zero and pi/4, and at the ends of the input range.
   localparam logic [15:0] FOLD_POINTS [8] = '{
      16'sd12868, -16'sd12868, 16'sd25736, -16'sd25736,
      16'sd0, 16'h7fff, 16'h8000, 16'sd6434
   };

   typedef logic [NUM_ENTRIES-1:0][15:0] matrix_type;

   typedef struct packed {
      logic [15:0] heading;
      logic [15:0] pitch;
      logic [15:0] bank;
      logic        is_identity;
   } angle_row_type;

   localparam int DIRECTED_COUNT = 20;
   localparam int TOTAL_ITEMS = DIRECTED_COUNT + RANDOM_ITEMS;
   localparam angle_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{16'sd0,       16'sd0,       16'sd0,       1'b1},
      '{16'h7fff,     16'h7fff,     16'h7fff,     1'b0},
      '{16'h8000,     16'h8000,     16'h8000,     1'b0},
      '{16'sd12868,   16'sd0,       16'sd0,       1'b0},
      '{-16'sd12868,  16'sd0,       16'sd0,       1'b0},
      '{16'sd0,       16'sd12868,   16'sd0,       1'b0},
      '{16'sd0,       -16'sd12868,  16'sd0,       1'b0},
      '{16'sd0,       16'sd0,       16'sd12868,   1'b0},
      '{16'sd0,       16'sd0,       -16'sd12868,  1'b0},
      '{16'sd25736,   16'sd0,       16'sd0,       1'b0},
      '{16'sd0,       16'sd25736,   16'sd0,       1'b0},
      '{16'sd0,       16'sd0,       -16'sd25736,  1'b0},
      '{16'sd12867,   16'sd12869,   -16'sd12867,  1'b0},
      '{-16'sd12869,  16'sd12869,   16'sd12867,   1'b0},
      '{16'h7fff,     16'h8000,     16'sd0,       1'b0},
      '{16'sd6434,    16'sd6434,    16'sd6434,    1'b0},
      '{-16'sd6434,   16'sd3217,    -16'sd9651,   1'b0},
      '{16'h5555,     16'haaaa,     16'sd1,       1'b0},
      '{-16'sd1,      16'sd1,       -16'sd1,      1'b0},
      '{16'sd25735,   -16'sd25737,  16'sd25737,   1'b0}
   };

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_heading = '0;
   logic signed [15:0] req_pitch = '0;
   logic signed [15:0] req_bank = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_basis_i_x, rsp_basis_i_y, rsp_basis_i_z;
   logic signed [15:0] rsp_basis_j_x, rsp_basis_j_y, rsp_basis_j_z;
   logic signed [15:0] rsp_basis_k_x, rsp_basis_k_y, rsp_basis_k_z;

   // Expected results in request order; the sender fills, the receiver drains.
   matrix_type expected_matrices [TOTAL_ITEMS];
   int sent_count = 0;
   int checked_count = 0;
   int error_count = 0;
   int cycle_count = 0;

   euler_to_rotation_matrix #(
      .CORDIC_STEPS(STEP_COUNT),
      .ANGLE_BITS(Z_FRAC)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_heading(req_heading),
      .req_pitch(req_pitch),
      .req_bank(req_bank),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_basis_i_x(rsp_basis_i_x),
      .rsp_basis_i_y(rsp_basis_i_y),
      .rsp_basis_i_z(rsp_basis_i_z),
      .rsp_basis_j_x(rsp_basis_j_x),
      .rsp_basis_j_y(rsp_basis_j_y),
      .rsp_basis_j_z(rsp_basis_j_z),
      .rsp_basis_k_x(rsp_basis_k_x),
      .rsp_basis_k_y(rsp_basis_k_y),
      .rsp_basis_k_z(rsp_basis_k_z)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Sine and cosine of one Q3.13 angle, both Q30, by rotation-mode CORDIC.
   function automatic void angle_sin_cos(input logic signed [15:0] angle,
                                         output longint sin_q30, output longint cos_q30);
      longint z, x, y, x_old, arc;
      bit folded;
      int i;
      z = longint'(angle) <<< (Z_FRAC - 13);
      folded = 1'b0;
      // Angles past +-pi/2 are folded by pi and the result negated afterwards.
      if (z > HALF_PI_Z) begin
         z = z - PI_Z;
         folded = 1'b1;
      end else if (z < -HALF_PI_Z) begin
         z = z + PI_Z;
         folded = 1'b1;
      end
      x = CORDIC_X0;
      y = 0;
      for (i = 0; i < STEP_COUNT; i++) begin
         arc = (ARCTAN_Q30[i] + TAB_HALF) >>> TAB_SHIFT;
         x_old = x;
         if (z >= 0) begin
            x = x - (y >>> i);
            y = y + (x_old >>> i);
            z = z - arc;
         end else begin
            x = x + (y >>> i);
            y = y - (x_old >>> i);
            z = z + arc;
         end
      end
      sin_q30 = folded ? -y : y;
      cos_q30 = folded ? -x : x;
   endfunction

   function automatic logic [15:0] round_q14(input longint q60);
      longint r;
      r = (q60 + (64'sd1 <<< 45)) >>> 46;
      if (r > 16384)
         r = 16384;
      else if (r < -16384)
         r = -16384;
      return r[15:0];
   endfunction

   function automatic matrix_type predict_rotation(input logic signed [15:0] heading,
                                                   input logic signed [15:0] pitch,
                                                   input logic signed [15:0] bank);
      longint sh, ch, sp, cp, sb, cb, shsp, chsp;
      matrix_type m;
      angle_sin_cos(heading, sh, ch);
      angle_sin_cos(pitch, sp, cp);
      angle_sin_cos(bank, sb, cb);
      shsp = (sh * sp) >>> 30;
      chsp = (ch * sp) >>> 30;
      m[I_X] = round_q14(ch * cb + shsp * sb);
      m[I_Y] = round_q14(sb * cp);
      m[I_Z] = round_q14(-(sh * cb) + chsp * sb);
      m[J_X] = round_q14(-(ch * sb) + shsp * cb);
      m[J_Y] = round_q14(cb * cp);
      m[J_Z] = round_q14(sb * sh + chsp * cb);
      m[K_X] = round_q14(sh * cp);
      m[K_Y] = round_q14(-(sp <<< 30));
      m[K_Z] = round_q14(ch * cp);
      return m;
   endfunction

   // Idle cycles before the next transaction; calm stretches run without any.
   function automatic int draw_idle(inout bit calm);
      if ($urandom_range(0, 39) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic [15:0] pick_angle();
      logic [15:0] near;
      if ($urandom_range(0, 9) < 3) begin
         near = FOLD_POINTS[$urandom_range(0, 7)];
         return near + 16'($urandom_range(0, 8)) - 16'd4;
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic send_angles(input logic [15:0] heading, input logic [15:0] pitch,
                              input logic [15:0] bank, input int idle,
                              input bit has_known, input matrix_type known);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_heading <= heading;
      req_pitch <= pitch;
      req_bank <= bank;
      do @(posedge clock); while (!req_ready);
      if (has_known)
         expected_matrices[sent_count] = known;
      else
         expected_matrices[sent_count] = predict_rotation(heading, pitch, bank);
      sent_count++;
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (checked_count != sent_count);
   endtask

   initial begin
      angle_row_type row;
      matrix_type identity;
      bit calm;
      int n;
      calm = 1'b0;
      identity = '0;
      identity[I_X] = ONE_Q14;
      identity[J_Y] = ONE_Q14;
      identity[K_Z] = ONE_Q14;
      while (reset) @(posedge clock);

      for (n = 0; n < DIRECTED_COUNT; n++) begin
         row = DIRECTED_ROWS[n];
         send_angles(row.heading, row.pitch, row.bank, draw_idle(calm),
                     row.is_identity, identity);
      end
      hold_until_drained();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2)
            hold_until_drained();
         send_angles(pick_angle(), pick_angle(), pick_angle(), draw_idle(calm),
                     1'b0, '0);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (checked_count != sent_count);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      matrix_type got, want;
      bit calm;
      int idle;
      int k;
      calm = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         idle = draw_idle(calm);
         if (idle > 0) begin
            rsp_ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got[I_X] = rsp_basis_i_x;
         got[I_Y] = rsp_basis_i_y;
         got[I_Z] = rsp_basis_i_z;
         got[J_X] = rsp_basis_j_x;
         got[J_Y] = rsp_basis_j_y;
         got[J_Z] = rsp_basis_j_z;
         got[K_X] = rsp_basis_k_x;
         got[K_Y] = rsp_basis_k_y;
         got[K_Z] = rsp_basis_k_z;
         if (checked_count >= sent_count) begin
            error_count++;
            if (error_count <= 10)
               $display("cycle %0d: response transaction with nothing outstanding",
                        cycle_count);
         end else begin
            want = expected_matrices[checked_count];
            checked_count++;
            for (k = 0; k < NUM_ENTRIES; k++) begin
               if (got[k] !== want[k]) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("cycle %0d: entry %0d expected %0d, got %0d", cycle_count,
                              k, $signed(want[k]), $signed(got[k]));
               end
            end
         end
      end
   end

endmodule
